// File: sv/row_mirror_sepia_pixel_stream_core_macros.svh
// Assertion macros for the row mirror sepia pixel stream core.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef ROW_MIRROR_SEPIA_PIXEL_STREAM_CORE_MACROS_SVH
`define ROW_MIRROR_SEPIA_PIXEL_STREAM_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rmsp_pkg.sv
// Shared types, codes and sepia arithmetic for the row mirror sepia core.
// No dependencies; imported by the top level, front end, queue and back end.
`default_nettype none

package rmsp_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int IMAGE_WIDTH_RST = 2048;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 12;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QCW             = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_MIRROR_ENABLE = 2'd1,
    CFG_SEPIA_ENABLE  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t pix;
    logic last;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           empty;
  } q_stat_t;

  // Sepia weights in thousandths.
  localparam logic [9:0] W_RR = 10'd393;
  localparam logic [9:0] W_RG = 10'd769;
  localparam logic [9:0] W_RB = 10'd189;
  localparam logic [9:0] W_GR = 10'd349;
  localparam logic [9:0] W_GG = 10'd686;
  localparam logic [9:0] W_GB = 10'd168;
  localparam logic [9:0] W_BR = 10'd272;
  localparam logic [9:0] W_BG = 10'd534;
  localparam logic [9:0] W_BB = 10'd131;

  localparam int SUM_W       = 20;
  localparam int PROD_W      = 40;
  localparam int RECIP_SHIFT = 29;
  // ceil(2^29 / 1000); exact for every sum below 2^20.
  localparam logic [SUM_W-1:0] RECIP_1000 = 20'd536871;

  function automatic logic [SUM_W-1:0] sepia_sum(pix_t p, logic [9:0] wr,
                                                  logic [9:0] wg, logic [9:0] wb);
    logic [SUM_W-1:0] s;
    s = SUM_W'(wr) * SUM_W'(p.red) + SUM_W'(wg) * SUM_W'(p.green)
      + SUM_W'(wb) * SUM_W'(p.blue);
    return s;
  endfunction

  function automatic logic [7:0] div1000_clamp(logic [SUM_W-1:0] s);
    logic [PROD_W-1:0]               prod;
    logic [PROD_W-RECIP_SHIFT-1:0]   quo;
    prod = PROD_W'(s) * PROD_W'(RECIP_1000);
    quo  = prod[PROD_W-1:RECIP_SHIFT];
    return (quo > (PROD_W-RECIP_SHIFT)'(255)) ? 8'd255 : quo[7:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/rmsp_stream_if.sv
// Valid/ready stream interfaces for the pixel input and result output.
// No dependencies.
`default_nettype none

interface rmsp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

interface rmsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       row_end;

  modport source (output valid, red_out, green_out, blue_out, row_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, row_end, output ready);
endinterface

`default_nettype wire

// File: sv/row_mirror_sepia_pixel_stream_core.sv
// Top level of the row mirror sepia pixel stream core: configuration
// registers, front end, queue and back end. Uses rmsp_pkg and the macro header.
//
//   Channel   Dir  Handshake            Beat contents
//   pix_i     in   valid/ready          opcode, red_in, green_in, blue_in
//   pix_o     out  valid/ready          red_out, green_out, blue_out, row_end
//   cfg       in   cfg_we_i, no wait    cfg_index_i, cfg_data_i
//
// One beat is accepted per cycle while the queue has room; a result passes through
// the row store read, queue, weighted sums, and divide and clamp in that order.
// The queue of four entries bounds acceptance when the output stalls.
// Reset clears control state only; the row store has no clearing pass.
`default_nettype none
`include "row_mirror_sepia_pixel_stream_core_macros.svh"

module row_mirror_sepia_pixel_stream_core
  import rmsp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  rmsp_in_if.sink                    pix_i,
  rmsp_out_if.source                 pix_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ? $clog2(MAX_WIDTH + 1)
                                                           : CFG_DATA_W;
  localparam int RST_WM1 = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH - 1
                                                         : IMAGE_WIDTH_RST - 1;

  logic [CW-1:0] wm1_q, wm1_d;
  logic          mirror_q, mirror_d;
  logic          sepia_q, sepia_d;
  logic [EW-1:0] iw_ext;
  cfg_idx_e      cfg_idx;

  q_push_t       q_push;
  q_stat_t       q_stat;
  q_entry_t      q_head;
  logic          q_pop;

  assign iw_ext  = EW'(cfg_data_i);
  assign cfg_idx = cfg_idx_e'(cfg_index_i);

  // The width register is kept as the clamped last column index.
  always_comb begin
    wm1_d    = wm1_q;
    mirror_d = mirror_q;
    sepia_d  = sepia_q;
    if (cfg_we_i) begin
      case (cfg_idx)
        CFG_IMAGE_WIDTH: begin
          if (iw_ext == '0) begin
            wm1_d = '0;
          end else if (iw_ext > EW'(MAX_WIDTH)) begin
            wm1_d = CW'(MAX_WIDTH - 1);
          end else begin
            wm1_d = CW'(iw_ext - EW'(1));
          end
        end
        CFG_MIRROR_ENABLE: mirror_d = cfg_data_i[0];
        CFG_SEPIA_ENABLE:  sepia_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q    <= CW'(RST_WM1);
      mirror_q <= 1'b0;
      sepia_q  <= 1'b0;
    end else begin
      wm1_q    <= wm1_d;
      mirror_q <= mirror_d;
      sepia_q  <= sepia_d;
    end
  end

  rmsp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .mirror_i (mirror_q),
    .wm1_i    (wm1_q),
    .q_stat_i (q_stat),
    .q_push_o (q_push)
  );

  rmsp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_push_i (q_push),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .q_stat_o (q_stat)
  );

  rmsp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sepia_i  (sepia_q),
    .head_i   (q_head),
    .q_stat_i (q_stat),
    .pop_o    (q_pop),
    .pix_o    (pix_o)
  );

  `RMSP_ASSERT_SAME(a_queue_room, q_push.push, q_stat.count < QCW'(QUEUE_DEPTH), "queue overrun")
  `RMSP_ASSERT_NEXT(a_drain_silent, pix_i.valid && pix_i.ready && pix_i.opcode == OP_DRAIN && !mirror_q, !q_push.push, "drain emitted while mirroring is off")
  `RMSP_ASSERT_NEXT(a_pass_emits, pix_i.valid && pix_i.ready && pix_i.opcode == OP_PIXEL && !mirror_q, q_push.push, "pass-through pixel not emitted")

endmodule

`default_nettype wire

// File: sv/rmsp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rmsp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/rmsp_front.sv
// Front end: accepts beats, tracks row state, drives the two-bank row store
// and hands emitted pixels to the queue. Uses rmsp_pkg, rmsp_ram, rmsp_in_if.
`default_nettype none

module rmsp_front
  import rmsp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rmsp_in_if.sink                            pix_i,
  input  wire logic                          mirror_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  wm1_i,
  input  wire q_stat_t                       q_stat_i,
  output q_push_t                            q_push_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(2 * MAX_WIDTH);

  logic [CW-1:0] cc_q, cc_d;
  logic          wbank_q, wbank_d;
  logic          prr_q, prr_d;

  logic          s1_valid_q;
  logic          s1_store_q;
  pix_t          s1_pix_q;
  logic          s1_last_q;

  logic          fire, is_drain, last;
  logic          emit_direct, emit_store, advance;
  logic [CW-1:0] rd_col;
  logic [AW-1:0] waddr, raddr;
  logic          we, re;
  pix_t          in_pix, rdata;
  logic [QCW:0]  occupancy;

  assign in_pix      = '{red: pix_i.red_in, green: pix_i.green_in, blue: pix_i.blue_in};
  assign occupancy   = (QCW+1)'(q_stat_i.count) + (QCW+1)'(s1_valid_q);
  assign pix_i.ready = occupancy < (QCW+1)'(QUEUE_DEPTH);
  assign fire        = pix_i.valid && pix_i.ready;
  assign is_drain    = (pix_i.opcode == OP_DRAIN);

  assign last        = cc_q >= wm1_i;
  assign rd_col      = last ? '0 : (wm1_i - cc_q);
  assign emit_direct = !mirror_i && !is_drain;
  assign emit_store  = mirror_i && prr_q;
  assign advance     = !is_drain || (mirror_i && prr_q);

  assign waddr = (wbank_q ? AW'(MAX_WIDTH) : '0) + AW'(cc_q);
  assign raddr = (wbank_q ? '0 : AW'(MAX_WIDTH)) + AW'(rd_col);
  assign we    = fire && mirror_i && !is_drain;
  assign re    = fire && emit_store;

  always_comb begin
    cc_d    = cc_q;
    wbank_d = wbank_q;
    prr_d   = prr_q;
    if (fire && advance) begin
      cc_d = last ? '0 : cc_q + CW'(1);
      if (mirror_i && last) begin
        if (is_drain) begin
          prr_d = 1'b0;
        end else begin
          wbank_d = ~wbank_q;
          prr_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q       <= '0;
      wbank_q    <= 1'b0;
      prr_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      cc_q       <= cc_d;
      wbank_q    <= wbank_d;
      prr_q      <= prr_d;
      s1_valid_q <= fire && (emit_direct || emit_store);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_store_q <= emit_store;
      s1_pix_q   <= in_pix;
      s1_last_q  <= last;
    end
  end

  rmsp_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (2 * MAX_WIDTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_pix),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign q_push_o.push       = s1_valid_q;
  assign q_push_o.entry.pix  = s1_store_q ? rdata : s1_pix_q;
  assign q_push_o.entry.last = s1_last_q;

endmodule

`default_nettype wire

// File: sv/rmsp_fifo.sv
// Short queue between the front end and the sepia back end.
// Uses rmsp_pkg.
`default_nettype none

module rmsp_fifo
  import rmsp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_push_t q_push_i,
  input  wire logic    pop_i,
  output q_entry_t     head_o,
  output q_stat_t      q_stat_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  q_entry_t       slot_q [QUEUE_DEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [QCW-1:0] count_q;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (q_push_i.push) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      count_q <= count_q + QCW'(q_push_i.push) - QCW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push_i.push) begin
      slot_q[wptr_q] <= q_push_i.entry;
    end
  end

  assign head_o         = slot_q[rptr_q];
  assign q_stat_o.count = count_q;
  assign q_stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// File: sv/rmsp_back.sv
// Back end: two-stage sepia pipeline ending in the output register; with sepia off pixels pass unchanged.
// Uses rmsp_pkg and rmsp_out_if.
`default_nettype none

module rmsp_back
  import rmsp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     sepia_i,
  input  wire q_entry_t head_i,
  input  wire q_stat_t  q_stat_i,
  output logic          pop_o,
  rmsp_out_if.source    pix_o
);

  logic             a_valid_q;
  logic [SUM_W-1:0] a_sum_r_q, a_sum_g_q, a_sum_b_q;
  pix_t             a_pix_q;
  logic             a_last_q;

  logic             b_valid_q;
  pix_t             b_pix_q, b_pix_d;
  logic             b_last_q;

  logic             a_adv, b_adv;

  assign b_adv = !b_valid_q || pix_o.ready;
  assign a_adv = !a_valid_q || b_adv;
  assign pop_o = !q_stat_i.empty && a_adv;

  always_comb begin
    if (sepia_i) begin
      b_pix_d.red   = div1000_clamp(a_sum_r_q);
      b_pix_d.green = div1000_clamp(a_sum_g_q);
      b_pix_d.blue  = div1000_clamp(a_sum_b_q);
    end else begin
      b_pix_d = a_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_q <= pop_o;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_sum_r_q <= sepia_sum(head_i.pix, W_RR, W_RG, W_RB);
      a_sum_g_q <= sepia_sum(head_i.pix, W_GR, W_GG, W_GB);
      a_sum_b_q <= sepia_sum(head_i.pix, W_BR, W_BG, W_BB);
      a_pix_q   <= head_i.pix;
      a_last_q  <= head_i.last;
    end
    if (b_adv && a_valid_q) begin
      b_pix_q  <= b_pix_d;
      b_last_q <= a_last_q;
    end
  end

  assign pix_o.valid     = b_valid_q;
  assign pix_o.red_out   = b_pix_q.red;
  assign pix_o.green_out = b_pix_q.green;
  assign pix_o.blue_out  = b_pix_q.blue;
  assign pix_o.row_end   = b_last_q;

endmodule

`default_nettype wire
